FILE: rtl/xmploc_pkg.sv
// Shared types, codes and the namespace signature for the XMP segment locator.
package xmploc_pkg;

   localparam int OFFSET_BITS = 26;
   localparam int SIG_LEN     = 29;
   localparam int IDX_BITS    = 5;

   localparam logic [7:0] BYTE_FILL  = 8'hFF;
   localparam logic [7:0] CODE_SOI   = 8'hD8;
   localparam logic [7:0] CODE_RST0  = 8'hD0;
   localparam logic [7:0] CODE_RST7  = 8'hD7;
   localparam logic [7:0] CODE_TEM   = 8'h01;
   localparam logic [7:0] CODE_SOS   = 8'hDA;
   localparam logic [7:0] CODE_EOI   = 8'hD9;
   localparam logic [7:0] CODE_APP0  = 8'hE0;
   localparam logic [7:0] CODE_APP1  = 8'hE1;

   localparam logic [1:0] REASON_XMP_FOUND = 2'd0;
   localparam logic [1:0] REASON_SCAN_END  = 2'd1;
   localparam logic [1:0] REASON_RAN_OUT   = 2'd2;
   localparam logic [1:0] REASON_MALFORMED = 2'd3;

   typedef enum logic [2:0] {
      PH_SOI0,
      PH_SOI1,
      PH_MARK,
      PH_CODE,
      PH_LENH,
      PH_LENL,
      PH_BODY,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]             end_reason;
      logic [OFFSET_BITS-1:0] segment_offset;
      logic [16:0]            segment_length;
      logic [OFFSET_BITS-1:0] insert_offset;
   } rsp_type;

   // Namespace string bytes followed by its zero terminator.
   function automatic logic [7:0] sig_byte(input logic [IDX_BITS-1:0] idx);
      logic [7:0] val;
      case (idx)
         5'd0:    val = 8'h68;
         5'd1:    val = 8'h74;
         5'd2:    val = 8'h74;
         5'd3:    val = 8'h70;
         5'd4:    val = 8'h3A;
         5'd5:    val = 8'h2F;
         5'd6:    val = 8'h2F;
         5'd7:    val = 8'h6E;
         5'd8:    val = 8'h73;
         5'd9:    val = 8'h2E;
         5'd10:   val = 8'h61;
         5'd11:   val = 8'h64;
         5'd12:   val = 8'h6F;
         5'd13:   val = 8'h62;
         5'd14:   val = 8'h65;
         5'd15:   val = 8'h2E;
         5'd16:   val = 8'h63;
         5'd17:   val = 8'h6F;
         5'd18:   val = 8'h6D;
         5'd19:   val = 8'h2F;
         5'd20:   val = 8'h78;
         5'd21:   val = 8'h61;
         5'd22:   val = 8'h70;
         5'd23:   val = 8'h2F;
         5'd24:   val = 8'h31;
         5'd25:   val = 8'h2E;
         5'd26:   val = 8'h30;
         5'd27:   val = 8'h2F;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/xmploc_parse.sv
// Marker segment walker: parse state, next-state logic and result forming.
module xmploc_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  xmploc_pkg::req_type item,
   output logic              result_valid,
   output xmploc_pkg::rsp_type result
);

   localparam int OB = xmploc_pkg::OFFSET_BITS;
   localparam int IB = xmploc_pkg::IDX_BITS;

   xmploc_pkg::phase_type phase_ff, phase_in;
   logic [OB-1:0] byte_position_ff, byte_position_in;
   logic [OB-1:0] marker_start_ff, marker_start_in;
   logic [OB-1:0] insert_position_ff, insert_position_in;
   logic          is_app1_ff, is_app1_in;
   logic          is_app01_ff, is_app01_in;
   logic [7:0]    length_high_ff, length_high_in;
   logic [15:0]   length_word_ff, length_word_in;
   logic [15:0]   bytes_left_ff, bytes_left_in;
   logic [IB-1:0] header_index_ff, header_index_in;
   logic          header_matches_ff, header_matches_in;

   logic [7:0]    b;
   logic          last;
   logic [15:0]   len_full;
   logic [15:0]   bytes_dec;
   logic          body_end;
   logic          hdr_open;
   logic [IB-1:0] idx_next;
   logic          match_next;
   logic          xmp_hit;
   logic          standalone;
   logic          ins_update;
   logic [OB-1:0] pos_next;
   logic [OB-1:0] ins_next;

   assign b         = item.data_byte;
   assign last      = item.last_byte;
   assign len_full  = {length_high_ff, b};
   assign bytes_dec = bytes_left_ff - 16'd1;
   assign body_end  = (bytes_dec == 16'd0);
   assign hdr_open  = (header_index_ff < IB'(xmploc_pkg::SIG_LEN));
   assign idx_next  = hdr_open ? header_index_ff + IB'(1) : header_index_ff;
   assign match_next = header_matches_ff &&
                       !(hdr_open && (b != xmploc_pkg::sig_byte(header_index_ff)));
   assign xmp_hit   = match_next && (idx_next >= IB'(xmploc_pkg::SIG_LEN));
   assign pos_next  = byte_position_ff + OB'(1);

   always_comb begin
      standalone = 1'b0;
      case (b) inside
         xmploc_pkg::CODE_SOI, xmploc_pkg::CODE_TEM,
         [xmploc_pkg::CODE_RST0:xmploc_pkg::CODE_RST7]: standalone = 1'b1;
         default: standalone = 1'b0;
      endcase
   end

   // An APP0/APP1 segment that closes moves the insert point past it.
   assign ins_update = is_app01_ff &&
                       (((phase_ff == xmploc_pkg::PH_LENL) && (len_full == 16'd2)) ||
                        ((phase_ff == xmploc_pkg::PH_BODY) && body_end && !xmp_hit));
   assign ins_next = ins_update ? pos_next : insert_position_ff;

   // Result forming.
   always_comb begin
      result_valid          = 1'b0;
      result.end_reason     = xmploc_pkg::REASON_MALFORMED;
      result.segment_offset = '0;
      result.segment_length = '0;
      result.insert_offset  = insert_position_ff;
      unique case (phase_ff)
         xmploc_pkg::PH_SOI0: result_valid = (b != xmploc_pkg::BYTE_FILL);
         xmploc_pkg::PH_SOI1: result_valid = (b != xmploc_pkg::CODE_SOI);
         xmploc_pkg::PH_MARK: result_valid = (b != xmploc_pkg::BYTE_FILL);
         xmploc_pkg::PH_CODE: begin
            if ((b == xmploc_pkg::CODE_SOS) || (b == xmploc_pkg::CODE_EOI)) begin
               result_valid      = 1'b1;
               result.end_reason = xmploc_pkg::REASON_SCAN_END;
            end
         end
         xmploc_pkg::PH_LENH: result_valid = 1'b0;
         xmploc_pkg::PH_LENL: result_valid = (len_full < 16'd2);
         xmploc_pkg::PH_BODY: begin
            if (body_end && xmp_hit) begin
               result_valid          = 1'b1;
               result.end_reason     = xmploc_pkg::REASON_XMP_FOUND;
               result.segment_offset = marker_start_ff;
               result.segment_length = {1'b0, length_word_ff} + 17'd2;
               result.insert_offset  = marker_start_ff;
            end
         end
         xmploc_pkg::PH_DONE: result_valid = 1'b0;
         default: result_valid = 1'b0;
      endcase
      if (last && !result_valid && (phase_ff != xmploc_pkg::PH_DONE)) begin
         result_valid          = 1'b1;
         result.end_reason     = xmploc_pkg::REASON_RAN_OUT;
         result.segment_offset = '0;
         result.segment_length = '0;
         result.insert_offset  = ins_next;
      end
   end

   // Next state.
   always_comb begin
      phase_in           = phase_ff;
      byte_position_in   = pos_next;
      marker_start_in    = marker_start_ff;
      insert_position_in = ins_next;
      is_app1_in         = is_app1_ff;
      is_app01_in        = is_app01_ff;
      length_high_in     = length_high_ff;
      length_word_in     = length_word_ff;
      bytes_left_in      = bytes_left_ff;
      header_index_in    = header_index_ff;
      header_matches_in  = header_matches_ff;
      unique case (phase_ff)
         xmploc_pkg::PH_SOI0: phase_in = xmploc_pkg::PH_SOI1;
         xmploc_pkg::PH_SOI1: phase_in = xmploc_pkg::PH_MARK;
         xmploc_pkg::PH_MARK: begin
            marker_start_in = byte_position_ff;
            phase_in        = xmploc_pkg::PH_CODE;
         end
         xmploc_pkg::PH_CODE: begin
            if (b == xmploc_pkg::BYTE_FILL) begin
               marker_start_in = byte_position_ff;
            end else if (standalone) begin
               phase_in = xmploc_pkg::PH_MARK;
            end else begin
               is_app1_in  = (b == xmploc_pkg::CODE_APP1);
               is_app01_in = (b == xmploc_pkg::CODE_APP1) || (b == xmploc_pkg::CODE_APP0);
               phase_in    = xmploc_pkg::PH_LENH;
            end
         end
         xmploc_pkg::PH_LENH: begin
            length_high_in = b;
            phase_in       = xmploc_pkg::PH_LENL;
         end
         xmploc_pkg::PH_LENL: begin
            length_word_in = len_full;
            if (len_full == 16'd2) begin
               bytes_left_in = '0;
               phase_in      = xmploc_pkg::PH_MARK;
            end else begin
               bytes_left_in     = len_full - 16'd2;
               header_index_in   = '0;
               header_matches_in = is_app1_ff &&
                                   (len_full >= 16'(2 + xmploc_pkg::SIG_LEN));
               phase_in          = xmploc_pkg::PH_BODY;
            end
         end
         xmploc_pkg::PH_BODY: begin
            header_index_in   = idx_next;
            header_matches_in = match_next;
            bytes_left_in     = bytes_dec;
            if (body_end) phase_in = xmploc_pkg::PH_MARK;
         end
         xmploc_pkg::PH_DONE: phase_in = xmploc_pkg::PH_DONE;
         default: phase_in = xmploc_pkg::PH_DONE;
      endcase
      if (result_valid) phase_in = xmploc_pkg::PH_DONE;
      // Last byte closes the stream: start the next one fresh.
      if (last) begin
         phase_in           = xmploc_pkg::PH_SOI0;
         byte_position_in   = '0;
         marker_start_in    = '0;
         insert_position_in = OB'(2);
         is_app1_in         = 1'b0;
         is_app01_in        = 1'b0;
         length_high_in     = '0;
         length_word_in     = '0;
         bytes_left_in      = '0;
         header_index_in    = '0;
         header_matches_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= xmploc_pkg::PH_SOI0;
         byte_position_ff   <= '0;
         marker_start_ff    <= '0;
         insert_position_ff <= OB'(2);
         is_app1_ff         <= 1'b0;
         is_app01_ff        <= 1'b0;
         length_high_ff     <= '0;
         length_word_ff     <= '0;
         bytes_left_ff      <= '0;
         header_index_ff    <= '0;
         header_matches_ff  <= 1'b1;
      end else if (step) begin
         phase_ff           <= phase_in;
         byte_position_ff   <= byte_position_in;
         marker_start_ff    <= marker_start_in;
         insert_position_ff <= insert_position_in;
         is_app1_ff         <= is_app1_in;
         is_app01_ff        <= is_app01_in;
         length_high_ff     <= length_high_in;
         length_word_ff     <= length_word_in;
         bytes_left_ff      <= bytes_left_in;
         header_index_ff    <= header_index_in;
         header_matches_ff  <= header_matches_in;
      end
   end

endmodule

FILE: rtl/jpeg_xmp_segment_locator_unit.sv
// Top level of the JPEG XMP segment locator: input register, walker, result register.
//
// Streams JPEG bytes in one per req transaction and returns one rsp transaction per
// stream: why the marker walk ended (XMP found, SOS/EOI reached, data ran out, or
// malformed), the XMP segment offset and total length, and the insert offset. A new
// byte is taken every cycle as long as the result register is empty or being
// drained. A byte accepted into the input register is parsed out of it
// combinationally, and a result it causes is loaded into the result register when
// the walker steps on that byte; rsp shows the result register. The only
// back-pressure path is the result register: while it holds an untaken result the
// walker holds its byte, and once the input register is full as well req_ready
// follows rsp_ready. After a result, bytes are dropped up to and including the one
// marked last_byte; the byte after that opens a new stream. Byte offsets wrap modulo
// 2^OFFSET_BITS. No configuration and no clearing pass after reset.
module jpeg_xmp_segment_locator_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  xmploc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output xmploc_pkg::rsp_type rsp_data
);

   logic                in_valid_ff, in_valid_in;
   xmploc_pkg::req_type in_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   xmploc_pkg::rsp_type rsp_data_ff;

   logic                advance;
   logic                step;
   logic                parse_valid;
   xmploc_pkg::rsp_type parse_result;

   // Advance the walker whenever the result register can take a new value.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   xmploc_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (in_data_ff),
      .result_valid (parse_valid),
      .result       (parse_result)
   );

   // Input register: load on each accepted transaction, drain when the walker steps.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: hold until taken, load when the walker emits.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && parse_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step && parse_valid) begin
         rsp_data_ff <= parse_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/xmploc_checker.sv
// Port-level checker for the XMP segment locator, bound to the top level.
module xmploc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input xmploc_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input xmploc_pkg::rsp_type rsp_data
);

   // Hold a stalled result transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Report no segment unless XMP was found.
   a_no_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.end_reason != xmploc_pkg::REASON_XMP_FOUND) |->
         (rsp_data.segment_offset == '0) && (rsp_data.segment_length == '0))
      else $error("segment fields set without XMP");

   // A found segment is its own insert point.
   a_found_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.end_reason == xmploc_pkg::REASON_XMP_FOUND) |->
         (rsp_data.insert_offset == rsp_data.segment_offset))
      else $error("insert offset differs from found segment");

   // A found segment holds marker, length and full signature.
   a_found_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.end_reason == xmploc_pkg::REASON_XMP_FOUND) |->
         (rsp_data.segment_length >= 17'(4 + xmploc_pkg::SIG_LEN)))
      else $error("XMP segment too short");

endmodule

bind jpeg_xmp_segment_locator_unit xmploc_checker u_xmploc_checker (.*);
